/* src/tne_pkg.sv */
// ----------------------------------------------------------------------------
// tne_pkg
// Shared types, codes and helpers of the TLV node extractor.
// ----------------------------------------------------------------------------
package tne_pkg;

  // Event header length used when the top level is not told otherwise.
  localparam int unsigned EVENT_HEADER_BYTES_DEF = 8;
  // Skip counter width: covers event headers of up to 15 bytes.
  localparam int unsigned SKIP_W = 4;
  localparam int unsigned NODE_HDR_BYTES = 8;
  // Result queue depth; must hold two entries beyond the one on the output.
  localparam int unsigned RQ_DEPTH = 4;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_GROUP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ITEM  = 1'd1;

  // Node payload kinds.
  localparam logic [7:0] KIND_I8  = 8'd1;
  localparam logic [7:0] KIND_I16 = 8'd2;
  localparam logic [7:0] KIND_I32 = 8'd3;
  localparam logic [7:0] KIND_F32 = 8'd4;

  // Element sizes in bytes.
  localparam logic [2:0] ESZ_NONE = 3'd0;
  localparam logic [2:0] ESZ_BYTE = 3'd1;
  localparam logic [2:0] ESZ_HALF = 3'd2;
  localparam logic [2:0] ESZ_WORD = 3'd4;

  // Closing status codes.
  localparam logic [1:0] ST_NOT_FOUND = 2'd0;
  localparam logic [1:0] ST_COMPLETE  = 2'd1;
  localparam logic [1:0] ST_TRUNC     = 2'd2;

  typedef struct packed {
    logic signed [31:0] value;
    logic               is_float;
    logic               closing;
    logic [1:0]         status;
  } result_t;

  function automatic logic [2:0] elem_size(input logic [7:0] kind);
    logic [2:0] sz;
    sz = ESZ_NONE;
    if (kind == KIND_I8) begin
      sz = ESZ_BYTE;
    end else if (kind == KIND_I16) begin
      sz = ESZ_HALF;
    end else if (kind == KIND_I32 || kind == KIND_F32) begin
      sz = ESZ_WORD;
    end
    return sz;
  endfunction

endpackage

/* src/tne_parser.sv */
// ----------------------------------------------------------------------------
// tne_parser
// Byte-wise walker: event header skip, node header capture, payload split.
// ----------------------------------------------------------------------------
module tne_parser #(
  parameter int unsigned EventHeaderBytes = tne_pkg::EVENT_HEADER_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic [7:0]       data_byte,
  input  logic             last,
  input  logic [15:0]      target_group,
  input  logic [7:0]       target_item,
  output logic [1:0]       push_cnt,
  output tne_pkg::result_t res0,
  output tne_pkg::result_t res1
);
  import tne_pkg::*;

  localparam logic [SKIP_W-1:0] SKIP_LAST = SKIP_W'(EventHeaderBytes);

  // Stream state.
  logic [SKIP_W-1:0] skip_r, skip_nxt;
  logic [2:0]        hcnt_r, hcnt_nxt;
  logic [31:0]       rem_r, rem_nxt;
  logic              match_r, match_nxt;
  logic              seen_r, seen_nxt;
  logic [7:0]        kind_r, kind_nxt;
  logic [1:0]        ecnt_r, ecnt_nxt;

  // Byte lanes: header bytes 0..6 and element bytes.
  logic [7:0] hdr_r  [NODE_HDR_BYTES-1];
  logic [7:0] elem_r [4];
  logic [7:0] cur    [4];

  logic        in_skip, in_pay, in_hdr, hdr_done, hit, elem_emit;
  logic [2:0]  size;
  logic [1:0]  cnt_inc;
  logic [31:0] hdr_len;
  logic [31:0] elem_val;
  logic [1:0]  close_status;
  result_t     elem_res, close_res;

  always_comb begin
    in_skip  = skip_r < SKIP_LAST;
    in_pay   = !in_skip && (rem_r != 32'd0);
    in_hdr   = !in_skip && (rem_r == 32'd0);
    hdr_done = in_hdr && (hcnt_r == 3'(NODE_HDR_BYTES - 1));
    hdr_len  = {data_byte, hdr_r[6], hdr_r[5], hdr_r[4]};
    hit      = !seen_r && ({hdr_r[1], hdr_r[0]} == target_group) &&
               (hdr_r[2] == target_item);
    size     = elem_size(kind_r);
    cnt_inc  = ecnt_r + 2'd1;
    for (int i = 0; i < 4; i++) begin
      cur[i] = (ecnt_r == 2'(i)) ? data_byte : elem_r[i];
    end
    elem_emit = in_pay && match_r && (size != ESZ_NONE) && (cnt_inc == size[1:0]);

    unique case (size)
      ESZ_BYTE: elem_val = {{24{cur[0][7]}}, cur[0]};
      ESZ_HALF: elem_val = {{16{cur[1][7]}}, cur[1], cur[0]};
      default:  elem_val = {cur[3], cur[2], cur[1], cur[0]};
    endcase

    // Advance the walk by one byte.
    skip_nxt  = skip_r;
    hcnt_nxt  = hcnt_r;
    rem_nxt   = rem_r;
    match_nxt = match_r;
    seen_nxt  = seen_r;
    kind_nxt  = kind_r;
    ecnt_nxt  = ecnt_r;
    if (step_en) begin
      priority if (in_skip) begin
        skip_nxt = skip_r + 1'b1;
      end else if (in_pay) begin
        rem_nxt = rem_r - 32'd1;
        if (match_r) begin
          if (size != ESZ_NONE) begin
            ecnt_nxt = elem_emit ? 2'd0 : cnt_inc;
          end
          if (rem_r == 32'd1) begin
            match_nxt = 1'b0;
            ecnt_nxt  = 2'd0;
          end
        end
      end else begin
        hcnt_nxt = hcnt_r + 3'd1;
        if (hdr_done) begin
          hcnt_nxt = 3'd0;
          rem_nxt  = hdr_len;
          ecnt_nxt = 2'd0;
          if (hit) begin
            seen_nxt  = 1'b1;
            kind_nxt  = hdr_r[3];
            match_nxt = hdr_len != 32'd0;
          end
        end
      end
    end

    if (!seen_nxt) begin
      close_status = ST_NOT_FOUND;
    end else if (match_nxt) begin
      close_status = ST_TRUNC;
    end else begin
      close_status = ST_COMPLETE;
    end

    // Drop all stream state after the final byte.
    if (step_en && last) begin
      skip_nxt  = '0;
      hcnt_nxt  = 3'd0;
      rem_nxt   = 32'd0;
      match_nxt = 1'b0;
      seen_nxt  = 1'b0;
      kind_nxt  = 8'd0;
      ecnt_nxt  = 2'd0;
    end

    elem_res.value    = elem_val;
    elem_res.is_float = kind_r == KIND_F32;
    elem_res.closing  = 1'b0;
    elem_res.status   = ST_NOT_FOUND;
    close_res.value    = 32'sd0;
    close_res.is_float = 1'b0;
    close_res.closing  = 1'b1;
    close_res.status   = close_status;

    push_cnt = step_en ? (2'(elem_emit) + 2'(last)) : 2'd0;
    res0     = elem_emit ? elem_res : close_res;
    res1     = close_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r  <= '0;
      hcnt_r  <= 3'd0;
      rem_r   <= 32'd0;
      match_r <= 1'b0;
      seen_r  <= 1'b0;
      kind_r  <= 8'd0;
      ecnt_r  <= 2'd0;
    end else begin
      skip_r  <= skip_nxt;
      hcnt_r  <= hcnt_nxt;
      rem_r   <= rem_nxt;
      match_r <= match_nxt;
      seen_r  <= seen_nxt;
      kind_r  <= kind_nxt;
      ecnt_r  <= ecnt_nxt;
    end
  end

  // Lanes are overwritten in place, so they need no clearing.
  always_ff @(posedge clk) begin
    if (step_en && in_hdr && !hdr_done) begin
      hdr_r[hcnt_r] <= data_byte;
    end
    if (step_en && in_pay && match_r) begin
      elem_r[ecnt_r] <= data_byte;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && last |=> skip_r == '0 && !seen_r && !match_r && rem_r == 32'd0)
    else $error("stream state not cleared after final byte");

  a_match_seen: assert property (@(posedge clk) disable iff (!rst_n)
    match_r |-> seen_r && rem_r != 32'd0)
    else $error("active match without pending payload");

  a_elem_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && elem_emit |-> !in_skip && match_r && ecnt_nxt == 2'd0)
    else $error("element emitted outside matched payload");

endmodule

/* src/tne_result_q.sv */
// ----------------------------------------------------------------------------
// tne_result_q
// Small result queue: takes up to two results per cycle, hands out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module tne_result_q #(
  parameter int unsigned Depth = tne_pkg::RQ_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_cnt,
  input  tne_pkg::result_t push0,
  input  tne_pkg::result_t push1,
  output logic             can_take,
  output logic             out_valid,
  input  logic             out_ready,
  output tne_pkg::result_t out_res
);
  import tne_pkg::*;

  localparam int unsigned PTR_W = $clog2(Depth);
  localparam int unsigned CNT_W = $clog2(Depth + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(Depth - 1);

  result_t          q_r [Depth];
  logic [PTR_W-1:0] head_r, head_nxt, tail_r, tail_nxt, tail1;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    out_valid = cnt_r != '0;
    out_res   = q_r[head_r];
    can_take  = cnt_r <= CNT_W'(Depth - 2);
    pop       = out_valid && out_ready;
    tail1     = ptr_inc(tail_r);
    head_nxt  = pop ? ptr_inc(head_r) : head_r;
    unique case (push_cnt)
      2'd1:    tail_nxt = tail1;
      2'd2:    tail_nxt = ptr_inc(tail1);
      default: tail_nxt = tail_r;
    endcase
    cnt_nxt = cnt_r + CNT_W'(push_cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      q_r[tail_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      q_r[tail1] <= push1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(Depth))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_cnt != 2'd0 |-> can_take)
    else $error("push without room for two results");

  a_close_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.closing |-> out_res.value == 32'sd0 && !out_res.is_float)
    else $error("closing result carries element data");

endmodule

/* src/tlv_node_extractor.sv */
// ----------------------------------------------------------------------------
// tlv_node_extractor
// Scans an event buffer byte by byte and streams out the payload elements of
// the first node that matches the configured group and item.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Carries
//  -------  -------------------  -------------------------------------------
//  in_      in_valid/in_ready    data_byte, end_of_buffer (one byte request)
//  out_     out_valid/out_ready  value, is_float, closing, status
//  cfg_     cfg_we (no wait)     cfg_index selects target_group/target_item
//
//  One byte request is taken per cycle while in_ready is high; its walk step
//  completes in the cycle it is accepted and its results land in a
//  four-entry result queue. A byte yields at most two results (an element
//  and the closing status), which enter the queue together.
//  in_ready holds low while the queue lacks room for two results; a stalled
//  output fills the queue and then stalls the input.
//  Reset (rst_n, synchronous) clears the walk, the queue and both targets;
//  there is no clearing pass.
// ----------------------------------------------------------------------------
module tlv_node_extractor #(
  parameter int unsigned EventHeaderBytes = tne_pkg::EVENT_HEADER_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tne_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tne_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_data_byte,
  input  logic                            in_end_of_buffer,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [31:0]              out_value,
  output logic                            out_is_float,
  output logic                            out_closing,
  output logic [1:0]                      out_status
);
  import tne_pkg::*;

  logic [15:0] target_group_r;
  logic [7:0]  target_item_r;
  logic        step_en;
  logic [1:0]  push_cnt;
  result_t     res0, res1, out_res;

  // The user must write the targets only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_group_r <= 16'd0;
      target_item_r  <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_GROUP: target_group_r <= cfg_wdata[15:0];
        REG_TARGET_ITEM:  target_item_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Advance the walk on every accepted byte request.
  assign step_en = in_valid && in_ready;

  tne_parser #(
    .EventHeaderBytes(EventHeaderBytes)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (step_en),
    .data_byte    (in_data_byte),
    .last         (in_end_of_buffer),
    .target_group (target_group_r),
    .target_item  (target_item_r),
    .push_cnt     (push_cnt),
    .res0         (res0),
    .res1         (res1)
  );

  tne_result_q #(
    .Depth(RQ_DEPTH)
  ) u_result_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (res0),
    .push1     (res1),
    .can_take  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_value    = out_res.value;
  assign out_is_float = out_res.is_float;
  assign out_closing  = out_res.closing;
  assign out_status   = out_res.status;

endmodule
